/* src/etok_pkg.sv */
// Shared types and constants for the expression tokenizer.
// Token record, per-character token bundle, and character and code constants.
// No dependencies.
package etok_pkg;

    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 3;
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int START_W    = 8;
    localparam int LEN_W      = 9;
    localparam int MAX_TOKENS = 4;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int IDX_W      = $clog2(MAX_TOKENS);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LEN_W-1:0] LEN_SAT = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER   = 3'd0,
        KIND_IDENT    = 3'd1,
        KIND_OPERATOR = 3'd2,
        KIND_BRACKET  = 3'd3,
        KIND_INVALID  = 3'd4,
        KIND_EOL      = 3'd5
    } kind_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_POWER = 3'd4,
        OP_MOD   = 3'd5
    } op_t;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_UC_M   = 8'h4D;

    localparam int KW_LEN = 3;
    localparam logic [CHAR_W-1:0] KW_TEXT [KW_LEN] = '{8'h4D, 8'h4F, 8'h44};

    typedef struct packed {
        kind_t                kind;
        op_t                  op;
        logic                 close;
        logic [VALUE_W-1:0]   value;
        logic                 ovf;
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     len;
    } token_t;

    typedef struct packed {
        token_t [MAX_TOKENS-1:0] tok;
        logic   [CNT_W-1:0]      count;
    } bundle_t;

endpackage

/* src/etok_char_if.sv */
// Character channel: valid/ready handshake with one line character.
// Depends on etok_pkg.
interface etok_char_if import etok_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              line_last;

    modport source (output valid, char_code, line_last, input ready);
    modport sink   (input valid, char_code, line_last, output ready);
endinterface

/* src/etok_token_if.sv */
// Token channel: valid/ready handshake with one token record.
// Depends on etok_pkg.
interface etok_token_if import etok_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         token_kind;
    logic [OP_W-1:0]           operator_code;
    logic                      close_bracket;
    logic signed [VALUE_W-1:0] number_value;
    logic                      overflow;
    logic [START_W-1:0]        token_start;
    logic [LEN_W-1:0]          token_length;
    logic                      run_last;

    modport source (output valid, token_kind, operator_code, close_bracket, number_value,
                    overflow, token_start, token_length, run_last, input ready);
    modport sink   (input valid, token_kind, operator_code, close_bracket, number_value,
                    overflow, token_start, token_length, run_last, output ready);
endinterface

/* src/etok_front.sv */
// Front end: takes one character per transfer, runs the lexer state and
// builds the bundle of up to three tokens that character completes.
// Depends on etok_pkg and etok_char_if.
module etok_front import etok_pkg::*; #(
    parameter int MAX_LINE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    etok_char_if.sink    chars,
    output logic         push_valid,
    input  logic         push_ready,
    output bundle_t      push_data
);

    localparam int POS_W = $clog2(MAX_LINE + 1);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_SKIP  = 2'd3
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic               held_valid_reg, held_valid_next;
    logic               held_star_reg, held_star_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic               prev_num_reg, prev_num_next;
    logic [1:0]         kw_reg, kw_next;

    logic [CHAR_W-1:0]  c;
    logic               over, is_digit, is_letter, is_under, is_space, take;
    logic [POS_W-1:0]   pos_inc, ident_off, len_v;
    logic [VALUE_W+3:0] prod;
    logic [VALUE_W+3:0] limit;
    logic [VALUE_W-1:0] dig;
    logic [CNT_W-1:0]   n_cnt;
    bundle_t            bundle;
    logic               accept;

    function automatic token_t tok_make(kind_t kind, op_t op, logic close,
                                        logic [VALUE_W-1:0] value, logic ovf,
                                        logic [POS_W-1:0] start, logic [POS_W-1:0] len);
        token_t t;
        t.kind  = kind;
        t.op    = op;
        t.close = close;
        t.value = value;
        t.ovf   = ovf;
        t.start = START_W'(start);
        if (32'(len) > 32'(LEN_SAT))
            t.len = LEN_SAT;
        else
            t.len = LEN_W'(len);
        return t;
    endfunction

    function automatic logic [VALUE_W-1:0] num_value(logic [VALUE_W-1:0] acc, logic neg,
                                                     logic ovf);
        if (ovf)
            return '0;
        else if (neg)
            return -acc;
        else
            return acc;
    endfunction

    assign accept      = chars.valid && chars.ready;
    assign chars.ready = push_ready;
    assign push_valid  = chars.valid && (n_cnt != '0);
    assign push_data   = bundle;

    always_comb
    begin
        mode_next       = mode_reg;
        held_valid_next = held_valid_reg;
        held_star_next  = held_star_reg;
        start_next      = start_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        ovf_next        = ovf_reg;
        prev_num_next   = prev_num_reg;
        kw_next         = kw_reg;
        bundle          = '0;
        n_cnt           = '0;
        take            = 1'b1;
        prod            = '0;
        len_v           = '0;

        c         = chars.char_code;
        over      = (pos_reg >= POS_W'(MAX_LINE));
        is_digit  = !over && (c >= CH_0) && (c <= CH_9);
        is_letter = !over && (((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
                              ((c >= CH_UC_A) && (c <= CH_UC_Z)));
        is_under  = !over && (c == CH_UNDER);
        is_space  = !over && ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)));
        dig       = VALUE_W'(c[3:0]);
        pos_inc   = (pos_reg < POS_W'(MAX_LINE)) ? pos_reg + 1'b1 : pos_reg;
        ident_off = pos_reg - start_reg;
        limit     = neg_reg ? (VALUE_W+4)'(33'h0_8000_0000) : (VALUE_W+4)'(33'h0_7FFF_FFFF);

        // token in progress
        case (mode_reg)
            MODE_SKIP:
            begin
                take = 1'b0;
            end
            MODE_NUM:
            begin
                if (is_digit)
                begin
                    take = 1'b0;
                    if (!ovf_reg)
                    begin
                        prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {4'b0, dig};
                        if (prod > limit)
                            ovf_next = 1'b1;
                        else
                            acc_next = prod[VALUE_W-1:0];
                    end
                end
                else
                begin
                    bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_NUMBER, OP_ADD, 1'b0,
                        num_value(acc_reg, neg_reg, ovf_reg), ovf_reg, start_reg,
                        pos_reg - start_reg);
                    n_cnt         = n_cnt + 1'b1;
                    prev_num_next = 1'b1;
                    mode_next     = MODE_IDLE;
                end
            end
            MODE_IDENT:
            begin
                if (is_letter || is_digit || is_under)
                begin
                    take = 1'b0;
                    if ((POS_W'(kw_reg) == ident_off) && (ident_off < POS_W'(KW_LEN)) &&
                        (c == KW_TEXT[ident_off[1:0]]))
                        kw_next = kw_reg + 1'b1;
                end
                else
                begin
                    len_v = pos_reg - start_reg;
                    if ((kw_reg == 2'd3) && (len_v == POS_W'(KW_LEN)))
                        bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR, OP_MOD, 1'b0,
                            '0, 1'b0, start_reg, len_v);
                    else
                        bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_IDENT, OP_ADD, 1'b0,
                            '0, 1'b0, start_reg, len_v);
                    n_cnt         = n_cnt + 1'b1;
                    prev_num_next = 1'b0;
                    mode_next     = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        // one-character lookahead for '*' and '-'
        if (take && held_valid_reg)
        begin
            held_valid_next = 1'b0;
            held_star_next  = 1'b0;
            if (held_star_reg)
            begin
                if (!over && (c == CH_STAR))
                begin
                    bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR, OP_POWER, 1'b0,
                        '0, 1'b0, start_reg, POS_W'(2));
                    take = 1'b0;
                end
                else
                    bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR, OP_MUL, 1'b0,
                        '0, 1'b0, start_reg, POS_W'(1));
                n_cnt         = n_cnt + 1'b1;
                prev_num_next = 1'b0;
            end
            else if (is_digit)
            begin
                mode_next = MODE_NUM;
                neg_next  = 1'b1;
                ovf_next  = 1'b0;
                acc_next  = dig;
                take      = 1'b0;
            end
            else
            begin
                bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR, OP_SUB, 1'b0,
                    '0, 1'b0, start_reg, POS_W'(1));
                n_cnt         = n_cnt + 1'b1;
                prev_num_next = 1'b0;
            end
        end

        // fresh character
        if (take)
        begin
            if (is_space)
            begin
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUM;
                start_next = pos_reg;
                neg_next   = 1'b0;
                ovf_next   = 1'b0;
                acc_next   = dig;
            end
            else if (is_letter)
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                kw_next    = (c == CH_UC_M) ? 2'd1 : 2'd0;
            end
            else if (!over && (c == CH_MINUS))
            begin
                if (prev_num_next)
                begin
                    bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR, OP_SUB, 1'b0,
                        '0, 1'b0, pos_reg, POS_W'(1));
                    n_cnt         = n_cnt + 1'b1;
                    prev_num_next = 1'b0;
                end
                else
                begin
                    held_valid_next = 1'b1;
                    held_star_next  = 1'b0;
                    start_next      = pos_reg;
                end
            end
            else if (!over && (c == CH_STAR))
            begin
                held_valid_next = 1'b1;
                held_star_next  = 1'b1;
                start_next      = pos_reg;
            end
            else if (!over && ((c == CH_PLUS) || (c == CH_SLASH)))
            begin
                bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR,
                    (c == CH_PLUS) ? OP_ADD : OP_DIV, 1'b0, '0, 1'b0, pos_reg, POS_W'(1));
                n_cnt         = n_cnt + 1'b1;
                prev_num_next = 1'b0;
            end
            else if (!over && ((c == CH_LPAREN) || (c == CH_RPAREN)))
            begin
                bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_BRACKET, OP_ADD,
                    (c == CH_RPAREN), '0, 1'b0, pos_reg, POS_W'(1));
                n_cnt         = n_cnt + 1'b1;
                prev_num_next = 1'b0;
            end
            else
            begin
                bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_INVALID, OP_ADD, 1'b0,
                    '0, 1'b0, pos_reg, POS_W'(1));
                n_cnt         = n_cnt + 1'b1;
                prev_num_next = 1'b0;
                mode_next     = MODE_SKIP;
            end
        end

        pos_next = pos_inc;

        // end of line: flush everything, then the end marker
        if (chars.line_last)
        begin
            len_v = pos_inc - start_next;
            if (mode_next == MODE_NUM)
            begin
                bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_NUMBER, OP_ADD, 1'b0,
                    num_value(acc_next, neg_next, ovf_next), ovf_next, start_next, len_v);
                n_cnt = n_cnt + 1'b1;
            end
            else if (mode_next == MODE_IDENT)
            begin
                if ((kw_next == 2'd3) && (len_v == POS_W'(KW_LEN)))
                    bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR, OP_MOD, 1'b0,
                        '0, 1'b0, start_next, len_v);
                else
                    bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_IDENT, OP_ADD, 1'b0,
                        '0, 1'b0, start_next, len_v);
                n_cnt = n_cnt + 1'b1;
            end
            if (held_valid_next)
            begin
                bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_OPERATOR,
                    held_star_next ? OP_MUL : OP_SUB, 1'b0, '0, 1'b0, start_next, POS_W'(1));
                n_cnt = n_cnt + 1'b1;
            end
            bundle.tok[n_cnt[IDX_W-1:0]] = tok_make(KIND_EOL, OP_ADD, 1'b0, '0, 1'b0,
                '0, '0);
            n_cnt = n_cnt + 1'b1;

            mode_next       = MODE_IDLE;
            held_valid_next = 1'b0;
            held_star_next  = 1'b0;
            pos_next        = '0;
            start_next      = '0;
            acc_next        = '0;
            neg_next        = 1'b0;
            ovf_next        = 1'b0;
            prev_num_next   = 1'b0;
            kw_next         = '0;
        end

        bundle.count = n_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_valid_reg <= 1'b0;
            held_star_reg  <= 1'b0;
            pos_reg        <= '0;
            start_reg      <= '0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            prev_num_reg   <= 1'b0;
            kw_reg         <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            held_valid_reg <= held_valid_next;
            held_star_reg  <= held_star_next;
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            ovf_reg        <= ovf_next;
            prev_num_reg   <= prev_num_next;
            kw_reg         <= kw_next;
        end
    end

endmodule

/* src/etok_queue.sv */
// Bundle queue between the front end and the token serializer.
// Depends on etok_pkg.
module etok_queue import etok_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  bundle_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output bundle_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    bundle_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/etok_back.sv */
// Back end: unpacks one bundle at a time and drives its tokens onto the
// token channel through an output register, marking the last of each bundle.
// Depends on etok_pkg and etok_token_if.
module etok_back import etok_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  bundle_t       pop_data,
    etok_token_if.source  tokens
);

    bundle_t          cur_reg;
    logic             cur_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    token_t           out_tok_reg;
    logic             out_last_reg;
    logic             load, cur_last, do_pop;

    assign load      = cur_valid_reg && (!out_valid_reg || tokens.ready);
    assign cur_last  = ((CNT_W'(idx_reg) + 1'b1) == cur_reg.count);
    assign pop_ready = !cur_valid_reg || (load && cur_last);
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (load && cur_last)
                cur_valid_reg <= 1'b0;
            else if (load)
                idx_reg <= idx_reg + 1'b1;

            if (load)
                out_valid_reg <= 1'b1;
            else if (tokens.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
            cur_reg <= pop_data;
        if (load)
        begin
            out_tok_reg  <= cur_reg.tok[idx_reg];
            out_last_reg <= cur_last;
        end
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.token_kind    = out_tok_reg.kind;
    assign tokens.operator_code = out_tok_reg.op;
    assign tokens.close_bracket = out_tok_reg.close;
    assign tokens.number_value  = out_tok_reg.value;
    assign tokens.overflow      = out_tok_reg.ovf;
    assign tokens.token_start   = out_tok_reg.start;
    assign tokens.token_length  = out_tok_reg.len;
    assign tokens.run_last      = out_last_reg;

endmodule

/* src/expression_tokenizer.sv */
// Expression line tokenizer, top level: front end, bundle queue, back end.
// Depends on etok_pkg, etok_char_if, etok_token_if, etok_front, etok_queue, etok_back.
//
//   channel  | dir | payload                                          | last mark
//   ---------+-----+--------------------------------------------------+----------
//   chars    | in  | char_code, line_last                             | line_last
//   tokens   | out | token_kind, operator_code, close_bracket,        | run_last
//            |     | number_value, overflow, token_start, token_length|
//
// One character per cycle is taken while the queue has room; a character that
// completes k tokens puts them on the token port (k is 0 to 3), one per cycle from
// the back end while tokens.ready is high, via the bundle and output registers.
// A four-entry bundle queue absorbs bursts; chars.ready drops only when it is full.
// Reset clears the line state and the queue; no token is valid after reset.
module expression_tokenizer import etok_pkg::*; #(
    parameter int MAX_LINE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    etok_char_if.sink    chars,
    etok_token_if.source tokens
);

    logic    push_valid, push_ready, pop_valid, pop_ready;
    bundle_t push_data, pop_data;

    etok_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    etok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    etok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .tokens    (tokens)
    );

    // end marker always closes its character's run
    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.token_kind == KIND_EOL)) |-> tokens.run_last)
        else $error("end-of-line token without run_last");

    // only number tokens carry a value or overflow
    a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.token_kind != KIND_NUMBER)) |->
        ((tokens.number_value == '0) && !tokens.overflow))
        else $error("value on non-number token");

    // overflowed number reads as zero
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.overflow) |-> (tokens.number_value == '0))
        else $error("overflow with nonzero value");

    // a bundle pushed into the queue is never empty
    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |-> (push_data.count != '0))
        else $error("empty bundle pushed");

endmodule
